// ----- rtl/vci_pkg.sv -----
// ----------------------------------------------------------------------------
// vci_pkg
// Shared types and constants of the valid-mode int16 convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package vci_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 32;
    localparam int IDX_W        = 6;
    localparam int TAPCFG_W     = 7;
    localparam int TAPCFG_MIN   = 2;
    localparam int TAPCFG_RESET = 2;

    localparam logic MODE_KERNEL = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic [IDX_W-1:0]           tap_index;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last_sample;
    } t_in_req;

    typedef struct packed {
        logic signed [SUM_W-1:0] result;
        logic                    last_result;
    } t_out_req;

    // Control broadcast from the sequencer to every tap cell
    typedef struct packed {
        logic                       shift;
        logic                       kernel_we;
        logic [IDX_W-1:0]           kernel_idx;
        logic signed [SAMPLE_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- rtl/vci_cell.sv -----
// ----------------------------------------------------------------------------
// vci_cell
// One tap: holds a window sample and a kernel word, registers their product
// and adds it to the partial sum coming from the previous tap.
// ----------------------------------------------------------------------------
`default_nettype none

module vci_cell #(
    parameter int IDX = 0,
    parameter int TW  = 7
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  vci_pkg::t_cell_ctl                      i_ctl,
    input  wire [TW-1:0]                            i_taps,
    input  wire logic signed [vci_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [vci_pkg::SAMPLE_W-1:0]     o_sample,
    input  wire logic signed [vci_pkg::SUM_W-1:0]    i_psum,
    output logic signed [vci_pkg::SUM_W-1:0]        o_psum
);
    import vci_pkg::*;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_kernel;
    logic signed [SUM_W-1:0]    r_prod;
    logic signed [SUM_W-1:0]    r_psum;
    logic signed [SUM_W-1:0]    n_prod;
    logic                       tap_on;
    logic                       kernel_hit;

    assign tap_on     = (i_taps > TW'(IDX));
    assign kernel_hit = i_ctl.kernel_we && (32'(i_ctl.kernel_idx) == 32'(IDX));
    assign n_prod     = r_sample * r_kernel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_ctl.shift) begin
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (kernel_hit) begin
            r_kernel <= i_ctl.value;
        end
        // taps beyond the active count contribute nothing
        r_prod <= tap_on ? n_prod : '0;
        r_psum <= i_psum + r_prod;
    end

    assign o_sample = r_sample;
    assign o_psum   = r_psum;

endmodule

`default_nettype wire

// ----- rtl/vci_ctrl.sv -----
// ----------------------------------------------------------------------------
// vci_ctrl
// Sequencer: tap count register, fill count, request handshake, timing of
// the sum ripple through the cell chain and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vci_ctrl #(
    parameter int MAX_TAPS = 64,
    parameter int TW       = 7
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [vci_pkg::TAPCFG_W-1:0]          i_cfg_wdata,
    input  wire                                  i_in_valid,
    input  vci_pkg::t_in_req                     i_in_req,
    output logic                                 o_in_stall,
    input  wire                                  i_out_stall,
    output logic                                 o_out_valid,
    output vci_pkg::t_out_req                    o_out_req,
    output vci_pkg::t_cell_ctl                   o_cell_ctl,
    output logic [TW-1:0]                        o_taps,
    input  wire logic signed [vci_pkg::SUM_W-1:0] i_sum
);
    import vci_pkg::*;

    localparam int FW       = $clog2(MAX_TAPS + 1);
    localparam int DONE_CNT = MAX_TAPS + 1;
    localparam int CW       = $clog2(DONE_CNT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    t_state                r_state, n_state;
    logic [TAPCFG_W-1:0]   r_tap_count;
    logic [FW-1:0]         r_fill, n_fill;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_last, n_last;
    logic                  r_out_valid, n_out_valid;
    t_out_req              r_out_req, n_out_req;

    logic [TW-1:0]         taps_eff;
    logic [TW-1:0]         tap_cfg;
    logic [FW-1:0]         fill_inc;
    logic                  accept;
    logic                  sample_in;
    logic                  emit;
    logic                  out_free;
    logic                  sum_ready;

    // clamp the tap count to the supported range
    always_comb begin
        tap_cfg = TW'(r_tap_count);
        if (tap_cfg < TW'(TAPCFG_MIN)) begin
            taps_eff = TW'(TAPCFG_MIN);
        end else if (tap_cfg > TW'(MAX_TAPS)) begin
            taps_eff = TW'(MAX_TAPS);
        end else begin
            taps_eff = tap_cfg;
        end
    end

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign sample_in = accept && (i_in_req.mode == MODE_SAMPLE);
    assign fill_inc  = (r_fill < FW'(MAX_TAPS)) ? r_fill + FW'(1) : r_fill;
    assign emit      = (TW'(fill_inc) >= taps_eff);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign sum_ready = (r_cnt == CW'(DONE_CNT));

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_req   = r_out_req;
        case (r_state)
            S_IDLE: begin
                if (sample_in) begin
                    n_fill = i_in_req.last_sample ? '0 : fill_inc;
                    if (emit) begin
                        n_state = S_RUN;
                        n_cnt   = '0;
                        n_last  = i_in_req.last_sample;
                    end
                end
            end
            S_RUN: begin
                if (!sum_ready) begin
                    n_cnt = r_cnt + CW'(1);
                end else if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_req.result      = i_sum;
                    n_out_req.last_result = r_last;
                    n_state               = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                // sum stays put: the window does not move until we go idle
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_req.result      = i_sum;
                    n_out_req.last_result = r_last;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_last    <= n_last;
        r_out_req <= n_out_req;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_tap_count <= TAPCFG_W'(TAPCFG_RESET);
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
        end
    end

    assign o_in_stall            = (r_state != S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_out_req             = r_out_req;
    assign o_taps                = taps_eff;
    assign o_cell_ctl.shift      = sample_in;
    assign o_cell_ctl.kernel_we  = accept && (i_in_req.mode == MODE_KERNEL);
    assign o_cell_ctl.kernel_idx = i_in_req.tap_index;
    assign o_cell_ctl.value      = i_in_req.value;

endmodule

`default_nettype wire

// ----- rtl/valid_convolution_i16.sv -----
// ----------------------------------------------------------------------------
// valid_convolution_i16
// Streaming valid-mode convolution of int16 samples with an int16 kernel.
// ----------------------------------------------------------------------------
// Requests with mode 0 write one kernel word into the tap cell named by
// tap_index; requests with mode 1 shift a sample into the window held across
// MAX_TAPS cells. Once the current vector holds tap_count samples, each
// sample gives one 32-bit wrapping sum of window times kernel. A kernel write,
// or a sample that gives no result, does not stall the input. A sample that
// gives a result is accepted, and the input then stalls while the product
// registers of all cells load, the partial sum ripples through the cell chain
// and the output register loads. The output register lets the next request
// enter while a result still waits. The user writes tap_count through
// i_cfg_we / i_cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module valid_convolution_i16 #(
    parameter int MAX_TAPS = 64
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [vci_pkg::TAPCFG_W-1:0] i_cfg_wdata,
    input  wire                         i_in_valid,
    input  vci_pkg::t_in_req            i_in_req,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output vci_pkg::t_out_req           o_out_req,
    input  wire                         i_out_stall
);
    import vci_pkg::*;

    localparam int TW = (TAPCFG_W > $clog2(MAX_TAPS + 1)) ? TAPCFG_W
                                                          : $clog2(MAX_TAPS + 1);

    t_cell_ctl                  cell_ctl;
    logic [TW-1:0]              taps;
    logic signed [SAMPLE_W-1:0] samp_chain [MAX_TAPS+1];
    logic signed [SUM_W-1:0]    psum_chain [MAX_TAPS+1];

    vci_ctrl #(
        .MAX_TAPS (MAX_TAPS),
        .TW       (TW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req),
        .o_cell_ctl  (cell_ctl),
        .o_taps      (taps),
        .i_sum       (psum_chain[MAX_TAPS])
    );

    assign samp_chain[0] = cell_ctl.value;
    assign psum_chain[0] = '0;

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        vci_cell #(
            .IDX (g),
            .TW  (TW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (cell_ctl),
            .i_taps   (taps),
            .i_sample (samp_chain[g]),
            .o_sample (samp_chain[g+1]),
            .i_psum   (psum_chain[g]),
            .o_psum   (psum_chain[g+1])
        );
    end

endmodule

`default_nettype wire

// ----- rtl/vci_checker.sv -----
// ----------------------------------------------------------------------------
// vci_checker
// Port-level checks of the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vci_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input vci_pkg::t_in_req  i_in_req,
    input wire               o_in_stall,
    input wire               o_out_valid,
    input vci_pkg::t_out_req o_out_req,
    input wire               i_out_stall
);
    import vci_pkg::*;

    // reset drops any pending result
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result changed or dropped");

    // kernel writes never make the block busy
    a_kernel_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_req.mode == MODE_KERNEL) |=> !o_in_stall)
        else $error("kernel write stalled the input");

    // a new result only appears at the end of a busy sum
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a computation");

endmodule

bind valid_convolution_i16 vci_checker u_vci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_req    (i_in_req),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_req   (o_out_req),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
